// ----- rtl/core/lcgbr_pkg.sv -----
package lcgbr_pkg;

    localparam int unsigned SEED_W   = 32;
    localparam int unsigned MUL_BITS = 12;
    localparam int unsigned MUL_CNT_W = $clog2(MUL_BITS);
    localparam int unsigned DIV_CNT_W = $clog2(SEED_W);

    localparam logic [SEED_W-1:0]   LCG_ADD   = SEED_W'(29573);
    localparam logic [SEED_W-1:0]   SEED_INIT = SEED_W'(42);
    localparam logic [MUL_BITS-1:0] LCG_MUL   = MUL_BITS'(3877);
    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_BITS - 1);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SEED_W - 1);

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SEED_W-1:0] operand;
    } t_req;

    typedef struct packed {
        logic [SEED_W-1:0] value;
        logic [SEED_W-1:0] seed_now;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/lcg_bounded_random.sv -----
// Bounded linear congruential random source.
// Input channel (i_in_valid / o_in_stall / i_in_data): a draw request carries
// an exclusive bound, a load request carries a new seed. Output channel
// (o_out_valid / i_out_stall / o_out_data): one result per request with the
// drawn value and the seed as it stands after the request.
// A draw with a nonzero bound steps the seed through a bit-serial multiply
// by the generator constant (one constant bit per cycle) and then a
// restoring remainder unit (one quotient bit per cycle). Such a draw
// then waits in the done state, which loads the output register once it is
// free. A load or a zero-bound draw goes from idle straight to done. One
// request is in work at a time: the next is taken only back in idle.
// The output register holds a finished result while the receiver stalls; the
// next request can be taken meanwhile, but its own result waits in the block
// until the register is free.
// Reset (synchronous, active low) sets the seed to 42 and empties the block.
module lcg_bounded_random
    import lcgbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    t_state               r_state;
    t_state               n_state;
    logic [SEED_W-1:0]    r_seed;
    logic [SEED_W-1:0]    r_bound;
    logic [SEED_W-1:0]    r_value;
    logic [SEED_W-1:0]    r_acc;
    logic [SEED_W-1:0]    r_sh;
    logic [MUL_BITS-1:0]  r_k;
    logic [MUL_CNT_W-1:0] r_mul_cnt;
    logic                 r_out_valid;
    t_rsp                 r_out_data;

    logic              w_in_xfer;
    logic              w_short;
    logic              w_mul_last;
    logic              w_div_start;
    logic              w_div_done;
    logic              w_out_free;
    logic              w_out_load;
    logic [SEED_W-1:0] w_acc_next;
    logic [SEED_W-1:0] w_div_rem;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_short    = (i_in_data.req_type == REQ_LOAD) || (i_in_data.operand == '0);
    assign w_mul_last = r_mul_cnt == MUL_LAST;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_acc_next = r_k[0] ? r_acc + r_sh : r_acc;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = w_short ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                if (w_mul_last) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = 1'b1;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE: o_in_stall  = 1'b0;
            ST_MUL:  w_div_start = w_mul_last;
            ST_DIV:  w_div_start = 1'b0;
            ST_DONE: w_out_load  = w_out_free;
            default: o_in_stall  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= SEED_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_xfer && i_in_data.req_type == REQ_LOAD) begin
                r_seed <= i_in_data.operand;
            end else if (w_div_start) begin
                r_seed <= w_acc_next;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_bound   <= i_in_data.operand;
            r_value   <= '0;
            r_acc     <= LCG_ADD;
            r_sh      <= r_seed;
            r_k       <= LCG_MUL;
            r_mul_cnt <= '0;
        end else if (r_state == ST_MUL) begin
            r_acc     <= w_acc_next;
            r_sh      <= {r_sh[SEED_W-2:0], 1'b0};
            r_k       <= {1'b0, r_k[MUL_BITS-1:1]};
            r_mul_cnt <= r_mul_cnt + 1'b1;
        end
        if (w_div_done) begin
            r_value <= w_div_rem;
        end
        if (w_out_load) begin
            r_out_data.value    <= r_value;
            r_out_data.seed_now <= r_seed;
        end
    end

    lcgbr_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc_next),
        .i_divisor  (r_bound),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ----- rtl/core/lcgbr_divider.sv -----
module lcgbr_divider
    import lcgbr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SEED_W-1:0] i_dividend,
    input  logic [SEED_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SEED_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SEED_W-1:0]    r_rem;
    logic [SEED_W-1:0]    r_dvd;
    logic [SEED_W-1:0]    r_dvs;
    logic [SEED_W:0]      w_trial;
    logic [SEED_W:0]      w_diff;
    logic                 w_ge;

    // one quotient bit per cycle
    assign w_trial = {r_rem, r_dvd[SEED_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SEED_W-1:0] : w_trial[SEED_W-1:0];
            r_dvd <= {r_dvd[SEED_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/lcgbr_checker.sv -----
module lcgbr_checker
    import lcgbr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input t_req i_in_data,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_data
);

    logic w_in_xfer;

    assign w_in_xfer = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("stalled result changed");

    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && i_in_data.req_type == REQ_LOAD && !o_out_valid
        |=> ##1 (o_out_valid && o_out_data.value == '0
                 && o_out_data.seed_now == $past(i_in_data.operand, 2)))
        else $error("load result wrong or late");

endmodule

bind lcg_bounded_random lcgbr_checker u_lcgbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ----- tb/lcg_bounded_random_chk.sv -----
`timescale 1ns / 100ps

module lcg_bounded_random_chk
    import lcgbr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_req i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_rsp i_out_data,
    output int   o_mismatches,
    output int   o_outstanding
);

    localparam int REPORT_LIMIT = 10;

    logic [SEED_W-1:0] seed_model;
    t_rsp              expected_rsp[$];
    int                mismatch_cnt = 0;

    // advance the seed copy and form the result of one request
    function t_rsp step_generator(input t_req req);
        t_rsp rsp;
        rsp.value = '0;
        if (req.req_type == REQ_LOAD) begin
            seed_model = req.operand;
        end else if (req.operand != '0) begin
            seed_model = seed_model * LCG_MUL + LCG_ADD;
            rsp.value  = seed_model % req.operand;
        end
        rsp.seed_now = seed_model;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp oldest;
        if (!i_rst_n) begin
            seed_model = SEED_INIT;
            expected_rsp.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsp.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_LIMIT)
                        $display("%t: unexpected result value=%h seed_now=%h", $time,
                                 i_out_data.value, i_out_data.seed_now);
                end else begin
                    oldest = expected_rsp.pop_front();
                    if (i_out_data.value !== oldest.value ||
                        i_out_data.seed_now !== oldest.seed_now) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_LIMIT)
                            $display("%t: mismatch value exp=%h act=%h, seed_now exp=%h act=%h",
                                     $time, oldest.value, i_out_data.value,
                                     oldest.seed_now, i_out_data.seed_now);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_rsp.push_back(step_generator(i_in_data));
        end
        o_mismatches  <= mismatch_cnt;
        o_outstanding <= expected_rsp.size();
    end

endmodule

// ----- tb/tb_lcg_bounded_random.sv -----
`timescale 1ns / 100ps

module tb_lcg_bounded_random;
    import lcgbr_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int ITEMS_PER_PHASE = 300;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_req i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_rsp o_out_data;

    int mismatches;
    int outstanding;
    int tx_idle_pct = 6;
    int rx_idle_pct = 59;
    int quiet_cycles = 0;

    lcg_bounded_random DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    lcg_bounded_random_chk u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_data    (o_out_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_lcg_bounded_random NOT OK");
            $finish;
        end
    end

    task automatic send_req(input logic kind, input logic [SEED_W-1:0] opnd);
        t_req req;
        req.req_type = kind;
        req.operand  = opnd;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // hold the sender until every transfer has its result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    task automatic send_random();
        int pick;
        logic [SEED_W-1:0] bound;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_req(REQ_LOAD, (pick < 2) ? {SEED_W{pick[0]}} : $urandom);
        end else begin
            case ($urandom_range(9))
                0:       bound = '0;
                1:       bound = SEED_W'(1);
                2, 3:    bound = SEED_W'($urandom_range(2, 16));
                4:       bound = SEED_W'($urandom_range(17, 65535));
                5, 6:    bound = SEED_W'(1) << $urandom_range(SEED_W - 1);
                7:       bound = {SEED_W{1'b1}} - SEED_W'($urandom_range(3));
                default: bound = $urandom;
            endcase
            send_req(REQ_DRAW, bound);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(REQ_DRAW, 32'h0000_0000);
        send_req(REQ_DRAW, 32'h0000_0001);
        send_req(REQ_DRAW, 32'hFFFF_FFFF);
        send_req(REQ_DRAW, 32'h8000_0000);
        send_req(REQ_DRAW, 32'h0000_0002);
        send_req(REQ_DRAW, 32'h0000_0003);
        send_req(REQ_DRAW, 32'h0000_0007);
        send_req(REQ_LOAD, 32'h0000_0000);
        send_req(REQ_DRAW, 32'h0000_0001);
        send_req(REQ_DRAW, 32'hFFFF_FFFF);
        send_req(REQ_LOAD, 32'hFFFF_FFFF);
        send_req(REQ_DRAW, 32'h0000_0000);
        send_req(REQ_DRAW, 32'hFFFF_FFFF);
        send_req(REQ_DRAW, 32'h0000_0001);
        send_req(REQ_LOAD, 32'h0000_002A);
        send_req(REQ_DRAW, 32'h0000_000A);
        send_req(REQ_LOAD, 32'h1234_5678);
        send_req(REQ_DRAW, 32'hFFFF_FFFE);
        send_req(REQ_DRAW, 32'h7FFF_FFFF);
        send_req(REQ_LOAD, 32'hA5A5_5A5A);
        send_req(REQ_DRAW, 32'h0000_0000);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 59;
                end
                1: begin
                    tx_idle_pct = 59;
                    rx_idle_pct = 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_random();
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_lcg_bounded_random OK");
        end else begin
            $display("tb_lcg_bounded_random NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/lcgbr_pkg.sv
rtl/core/lcgbr_divider.sv
rtl/core/lcg_bounded_random.sv
rtl/core/lcgbr_checker.sv
tb/lcg_bounded_random_chk.sv
tb/tb_lcg_bounded_random.sv
